// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the ring queue control logic. Define ASSERT_OFF to drop
// every checker from the build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is high.
`define SRQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRQ_ASSERT(lbl, clk, rst, prop, msg)
`define SRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/srq_pkg.sv -----
// ----------------------------------------------------------------------------
// srq_pkg
// Sizes, status codes and the control structures of the session tagged
// ring queue.
// ----------------------------------------------------------------------------
package srq_pkg;

  // Storage geometry.
  localparam int DEPTH        = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int SLOT_W       = $clog2(DEPTH);

  // Fixed field widths of the interface.
  localparam int DATA_W   = 64;
  localparam int TAG_W    = 64;
  localparam int CAP_W    = 7;
  localparam int STATUS_W = 3;
  localparam int DROP_W   = 32;
  localparam int IDX_W    = 2;

  // Request types.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_CAPACITY   = 2'd0;
  localparam logic [IDX_W-1:0] REG_GENERATION = 2'd1;
  localparam logic [IDX_W-1:0] REG_NONCE      = 2'd2;
  localparam logic [IDX_W-1:0] REG_ACCEPTING  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;

  // Outcome of one request as decided by the control stage.
  typedef struct packed {
    logic [STATUS_W-1:0] status;   // final unless a pop must check its tag
    logic                pop_hit;  // a stored record was consumed
    logic [DROP_W-1:0]   drop;     // drop counter after the request
    logic [CAP_W-1:0]    fill;     // entries held after the request
  } exec_t;

  // Slot store write request.
  typedef struct packed {
    logic                    en;
    logic [SLOT_W-1:0]       addr;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [TAG_W-1:0]        generation;
    logic [TAG_W-1:0]        nonce;
  } store_wr_t;

  // Slot store read request.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } store_rd_t;

endpackage

// ----- rtl/srq_store.sv -----
// ----------------------------------------------------------------------------
// srq_store
// Slot memory of the ring queue: payload, generation and nonce per slot,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module srq_store
  import srq_pkg::*;
(
  input  logic                    clk,
  input  store_wr_t               wr,
  input  store_rd_t               rd,
  output logic [PAYLOAD_BITS-1:0] rd_payload,
  output logic [TAG_W-1:0]        rd_generation,
  output logic [TAG_W-1:0]        rd_nonce
);

  logic [PAYLOAD_BITS-1:0] mem_payload    [DEPTH];
  logic [TAG_W-1:0]        mem_generation [DEPTH];
  logic [TAG_W-1:0]        mem_nonce      [DEPTH];

  // Write a pushed record into its slot.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_payload[wr.addr]    <= wr.payload;
      mem_generation[wr.addr] <= wr.generation;
      mem_nonce[wr.addr]      <= wr.nonce;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_payload    <= mem_payload[rd.addr];
      rd_generation <= mem_generation[rd.addr];
      rd_nonce      <= mem_nonce[rd.addr];
    end
  end

endmodule

// ----- rtl/srq_ctrl.sv -----
// ----------------------------------------------------------------------------
// srq_ctrl
// Configuration registers, ring pointers, fill count and drop counter.
// Decides the outcome of each request and drives the slot store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srq_ctrl
  import srq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  input  logic              go,
  input  logic              req_type,
  input  logic [DATA_W-1:0] req_payload,
  input  logic [TAG_W-1:0]  req_generation,
  input  logic [TAG_W-1:0]  req_nonce,
  output exec_t             res,
  output store_wr_t         wr,
  output store_rd_t         rd,
  output logic [TAG_W-1:0]  cur_generation,
  output logic [TAG_W-1:0]  cur_nonce
);

  logic [CAP_W-1:0]  capacity;
  logic              accepting;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [CAP_W-1:0]  held_count;
  logic [DROP_W-1:0] drop_counter;

  logic [SLOT_W-1:0] write_slot_next;
  logic [SLOT_W-1:0] read_slot_next;
  logic [CAP_W-1:0]  held_count_next;
  logic [DROP_W-1:0] drop_counter_next;
  logic              queue_ok;
  logic              tag_ok;
  logic              do_push;

  // Pointer advance that wraps at the configured capacity.
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p,
                                                  input logic [CAP_W-1:0]  cap);
    logic [SLOT_W:0] n;
    n = {1'b0, p} + 1'b1;
    if (32'(n) >= 32'(cap) || 32'(n) >= 32'(DEPTH)) begin
      return '0;
    end
    return n[SLOT_W-1:0];
  endfunction

  // Queue validity and tag match of the incoming record.
  assign queue_ok = (capacity != '0) && (32'(capacity) <= 32'(DEPTH)) &&
                    (cur_generation != '0) && (cur_nonce != '0);
  assign tag_ok   = (req_generation == cur_generation) &&
                    (req_nonce == cur_nonce);

  // Decide the outcome in the order of the checks.
  always_comb begin
    res.status        = ST_ACCEPTED;
    res.pop_hit       = 1'b0;
    do_push           = 1'b0;
    write_slot_next   = write_slot;
    read_slot_next    = read_slot;
    held_count_next   = held_count;
    drop_counter_next = drop_counter;
    if (!queue_ok) begin
      res.status = ST_INVALID;
    end else if (req_type == REQ_PUSH) begin
      if (!tag_ok) begin
        res.status = ST_INVALID;
      end else if (!accepting) begin
        res.status = ST_DISABLED;
      end else if (held_count >= capacity) begin
        drop_counter_next = drop_counter + 1'b1;
        res.status        = ST_FULL;
      end else begin
        do_push         = 1'b1;
        write_slot_next = next_slot(write_slot, capacity);
        held_count_next = held_count + 1'b1;
      end
    end else begin
      if (!accepting) begin
        res.status = ST_DISABLED;
      end else if (held_count == '0) begin
        res.status = ST_EMPTY;
      end else begin
        res.pop_hit     = 1'b1;
        read_slot_next  = next_slot(read_slot, capacity);
        held_count_next = held_count - 1'b1;
      end
    end
    res.drop = drop_counter_next;
    res.fill = held_count_next;
  end

  // Slot store requests.
  always_comb begin
    wr.en         = go && do_push;
    wr.addr       = write_slot;
    wr.payload    = req_payload[PAYLOAD_BITS-1:0];
    wr.generation = req_generation;
    wr.nonce      = req_nonce;
    rd.en         = go && res.pop_hit;
    rd.addr       = read_slot;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= '0;
      cur_generation <= '0;
      cur_nonce      <= '0;
      accepting      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY:   capacity       <= cfg_data[CAP_W-1:0];
        REG_GENERATION: cur_generation <= cfg_data[TAG_W-1:0];
        REG_NONCE:      cur_nonce      <= cfg_data[TAG_W-1:0];
        REG_ACCEPTING:  accepting      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Queue state; a capacity write empties the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      read_slot    <= '0;
      held_count   <= '0;
      drop_counter <= '0;
    end else if (cfg_we && cfg_index == REG_CAPACITY) begin
      write_slot <= '0;
      read_slot  <= '0;
      held_count <= '0;
    end else if (go) begin
      write_slot   <= write_slot_next;
      read_slot    <= read_slot_next;
      held_count   <= held_count_next;
      drop_counter <= drop_counter_next;
    end
  end

  // The ring never holds more entries than its capacity.
  `SRQ_ASSERT(a_held_within_cap, clk, rst, held_count <= capacity,
              "held count exceeds capacity")
  // A consumed record lowers the fill count by exactly one.
  `SRQ_ASSERT(a_pop_lowers_fill, clk, rst,
              go && res.pop_hit && !cfg_we |=> held_count + 1'b1 == $past(held_count),
              "pop did not lower the fill count by one")
  // The drop counter moves only on a push refused as full.
  `SRQ_ASSERT(a_drop_only_full, clk, rst,
              !(go && res.status == ST_FULL) |=> drop_counter == $past(drop_counter),
              "drop counter moved without a full push")
  // Reads and writes of the slot store never coincide.
  `SRQ_ASSERT(a_one_port_op, clk, rst, !(wr.en && rd.en),
              "slot store read and write in the same cycle")

endmodule

// ----- rtl/session_tagged_ring_queue_core.sv -----
// ----------------------------------------------------------------------------
// session_tagged_ring_queue_core
// Bounded FIFO of session tagged records with a wrapping drop counter.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (in_valid/in_ready) is a push or
// a pop of one record and yields exactly one result on the output channel
// (out_valid/out_ready): status, popped payload, drop total and fill level.
// Configuration is written through cfg_we/cfg_index/cfg_data while the queue
// has no request in flight; a capacity write empties the ring.
// A request passes the input register, the control result register and the
// result register in turn. Throughput: one request per cycle while the
// receiver does not stall, set by the single write port and the single
// registered read port of the slot memory.
// Pipeline: input register, control and slot access, tag check into the
// result register. While the receiver stalls, the stages ahead keep filling,
// so up to two further requests are taken before in_ready drops.
// Reset clears the configuration, the pointers, the fill count and the drop
// counter and empties the pipeline; slot contents are not cleared.
// ----------------------------------------------------------------------------
module session_tagged_ring_queue_core
  import srq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [DATA_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [DATA_W-1:0]   payload,
  input  logic [TAG_W-1:0]    rec_generation,
  input  logic [TAG_W-1:0]    rec_nonce,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [DATA_W-1:0]   read_payload,
  output logic [DROP_W-1:0]   drop_total,
  output logic [CAP_W-1:0]    fill_level
);

  // Input register.
  logic              s1_valid;
  logic              s1_req_type;
  logic [DATA_W-1:0] s1_payload;
  logic [TAG_W-1:0]  s1_generation;
  logic [TAG_W-1:0]  s1_nonce;

  // Control result register.
  logic  s2_valid;
  exec_t s2_res;

  logic                    s1_adv;
  logic                    s2_adv;
  exec_t                   res;
  store_wr_t               wr;
  store_rd_t               rd;
  logic [TAG_W-1:0]        cur_generation;
  logic [TAG_W-1:0]        cur_nonce;
  logic [PAYLOAD_BITS-1:0] rd_payload;
  logic [TAG_W-1:0]        rd_generation;
  logic [TAG_W-1:0]        rd_nonce;
  logic                    stored_tag_ok;

  // Stage advance: each stage moves when the one ahead is free or moving.
  assign s2_adv   = s2_valid && (!out_valid || out_ready);
  assign s1_adv   = s1_valid && (!s2_valid || s2_adv);
  assign in_ready = !s1_valid || !s2_valid || s2_adv;

  // Input register takes a request.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_type   <= req_type;
      s1_payload    <= payload;
      s1_generation <= rec_generation;
      s1_nonce      <= rec_nonce;
    end
  end

  srq_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .go             (s1_adv),
    .req_type       (s1_req_type),
    .req_payload    (s1_payload),
    .req_generation (s1_generation),
    .req_nonce      (s1_nonce),
    .res            (res),
    .wr             (wr),
    .rd             (rd),
    .cur_generation (cur_generation),
    .cur_nonce      (cur_nonce)
  );

  srq_store u_store (
    .clk           (clk),
    .wr            (wr),
    .rd            (rd),
    .rd_payload    (rd_payload),
    .rd_generation (rd_generation),
    .rd_nonce      (rd_nonce)
  );

  // Control result register, next to the registered slot read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_res <= res;
    end
  end

  // A consumed record must still carry the current session tag.
  assign stored_tag_ok = (rd_generation == cur_generation) &&
                         (rd_nonce == cur_nonce);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      drop_total <= s2_res.drop;
      fill_level <= s2_res.fill;
      if (s2_res.pop_hit && !stored_tag_ok) begin
        status       <= ST_INVALID;
        read_payload <= '0;
      end else if (s2_res.pop_hit) begin
        status       <= s2_res.status;
        read_payload <= DATA_W'(rd_payload);
      end else begin
        status       <= s2_res.status;
        read_payload <= '0;
      end
    end
  end

endmodule
